@@ design/json_pretty_printer_defines.svh @@
// Assertion macros used by the checker file jpp_checker.sv.
`ifndef JSON_PRETTY_PRINTER_DEFINES_SVH
`define JSON_PRETTY_PRINTER_DEFINES_SVH

// Implication in the same cycle.
`define JPP_ASSERT_NOW(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Implication in the next cycle.
`define JPP_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

@@ design/jpp_pkg.sv @@
// Package for the JSON pretty printer: constants, item types and sequencer states.
package jpp_pkg;

  localparam int MAX_DEPTH = 32;
  localparam int DEPTH_W   = 6;
  localparam int K_W       = DEPTH_W + 1;
  localparam int CAP_W     = 20;
  localparam logic [CAP_W-1:0] CAP_RESET = 20'hFFFFF;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_valid;
    logic       end_of_doc;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       doc_done;
    logic       doc_error;
  } res_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_COMMA,
    S_NEWLINE,
    S_TABS,
    S_CHAR,
    S_COLON,
    S_SPACE,
    S_END,
    S_ERROR
  } state_t;

endpackage

@@ design/json_pretty_printer.sv @@
// JSON pretty printer: re-indents a byte stream, one output byte per cycle.
//
// Input items carry one JSON byte (or a bare end marker) and are taken only
// while the sequencer is idle. After an item is accepted, S_DISPATCH decodes it,
// then the sequencer emits its results one per cycle through the output
// register: a plain byte passes S_DISPATCH and S_CHAR before the next ready,
// whitespace and commas only S_DISPATCH, and a held comma before a value adds
// ',' then '\n' and a tab per level of depth; a first entry adds '\n' and tabs.
// Every output byte goes past one shared add-and-compare unit that checks
// bytes_written against output_capacity; a newline with its tabs and ": " are
// checked as a whole before their first byte. A stalled output register holds
// the sequencer in place. On an error one error item goes out and input is
// dropped until the end of the document, which gives a done+error item.
// output_capacity may only be written while no item is in flight.
module json_pretty_printer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  jpp_pkg::in_item_t         in_item,
  output logic                      res_valid,
  input  logic                      res_ready,
  output jpp_pkg::res_item_t        res_item,
  input  logic                      cfg_we,
  input  logic [jpp_pkg::CAP_W-1:0] cfg_wdata
);

  jpp_pkg::state_t state, state_next;
  jpp_pkg::in_item_t cur;

  logic [jpp_pkg::CAP_W-1:0]   output_capacity;
  logic [jpp_pkg::DEPTH_W-1:0] nesting_depth, nesting_depth_next;
  logic                        opened_flag, opened_flag_next;
  logic                        comma_pending, comma_pending_next;
  logic                        inside_string, inside_string_next;
  logic                        after_backslash, after_backslash_next;
  logic [jpp_pkg::CAP_W-1:0]   bytes_written, bytes_written_next;
  logic                        failed_flag, failed_flag_next;
  logic [jpp_pkg::DEPTH_W-1:0] nl_depth, nl_depth_next;
  logic [jpp_pkg::DEPTH_W-1:0] tab_cnt, tab_cnt_next;
  logic                        res_valid_next;
  jpp_pkg::res_item_t          res_item_next;

  // the sequencer may move while the output register is free or draining
  logic adv;
  assign adv      = !res_valid || res_ready;
  assign in_ready = (state == jpp_pkg::S_IDLE);

  // shared room check: bytes_written + k <= output_capacity
  logic [jpp_pkg::K_W-1:0]   room_k;
  logic [jpp_pkg::CAP_W:0]   room_sum;
  logic                      room_ok;

  always_comb begin
    case (state)
      jpp_pkg::S_NEWLINE: room_k = {1'b0, nl_depth} + jpp_pkg::K_W'(1);
      jpp_pkg::S_COLON:   room_k = jpp_pkg::K_W'(2);
      default:            room_k = jpp_pkg::K_W'(1);
    endcase
    room_sum = {1'b0, bytes_written} + (jpp_pkg::CAP_W + 1)'(room_k);
    room_ok  = room_sum <= {1'b0, output_capacity};
  end

  // where to go once this item's own bytes are out
  jpp_pkg::state_t after_value;
  assign after_value = cur.end_of_doc ? jpp_pkg::S_END : jpp_pkg::S_IDLE;

  // decode of the latched item (used in S_DISPATCH)
  jpp_pkg::state_t             d_state, pfx_state;
  logic [jpp_pkg::DEPTH_W-1:0] d_depth, d_nl_depth;
  logic                        d_opened, d_comma, d_instr, d_bslash;

  always_comb begin
    d_depth    = nesting_depth;
    d_nl_depth = nesting_depth;
    d_opened   = opened_flag;
    d_comma    = comma_pending;
    d_instr    = inside_string;
    d_bslash   = after_backslash;
    d_state    = jpp_pkg::S_IDLE;
    // value prefix: pending comma, else first-entry newline
    if (comma_pending) begin
      pfx_state = jpp_pkg::S_COMMA;
    end else if (opened_flag) begin
      pfx_state = jpp_pkg::S_NEWLINE;
    end else begin
      pfx_state = jpp_pkg::S_CHAR;
    end
    if (failed_flag) begin
      d_state = cur.end_of_doc ? jpp_pkg::S_ERROR : jpp_pkg::S_IDLE;
    end else if (!cur.byte_valid) begin
      d_state = after_value;
    end else if (inside_string) begin
      if (after_backslash) begin
        d_bslash = 1'b0;
        d_state  = jpp_pkg::S_CHAR;
      end else if (cur.in_byte == jpp_pkg::CH_NUL || cur.in_byte == jpp_pkg::CH_CR ||
                   cur.in_byte == jpp_pkg::CH_NL) begin
        d_state = jpp_pkg::S_ERROR;
      end else begin
        if (cur.in_byte == jpp_pkg::CH_QUOTE) begin
          d_instr = 1'b0;
        end else if (cur.in_byte == jpp_pkg::CH_BSLASH) begin
          d_bslash = 1'b1;
        end
        d_state = jpp_pkg::S_CHAR;
      end
    end else begin
      case (cur.in_byte)
        jpp_pkg::CH_SP, jpp_pkg::CH_TAB, jpp_pkg::CH_NL, jpp_pkg::CH_CR: begin
          d_state = after_value;
        end
        jpp_pkg::CH_LBRACE, jpp_pkg::CH_LBRACK: begin
          if (nesting_depth >= jpp_pkg::DEPTH_W'(jpp_pkg::MAX_DEPTH)) begin
            d_state = jpp_pkg::S_ERROR;
          end else begin
            // prefix newline indents at the old depth
            d_state  = pfx_state;
            d_opened = 1'b1;
            d_comma  = 1'b0;
            d_depth  = nesting_depth + jpp_pkg::DEPTH_W'(1);
          end
        end
        jpp_pkg::CH_RBRACE, jpp_pkg::CH_RBRACK: begin
          if (nesting_depth == '0) begin
            d_state = jpp_pkg::S_ERROR;
          end else begin
            // empty container stays collapsed; a trailing comma is dropped
            d_depth    = nesting_depth - jpp_pkg::DEPTH_W'(1);
            d_nl_depth = nesting_depth - jpp_pkg::DEPTH_W'(1);
            d_opened   = 1'b0;
            d_comma    = 1'b0;
            d_state    = opened_flag ? jpp_pkg::S_CHAR : jpp_pkg::S_NEWLINE;
          end
        end
        jpp_pkg::CH_COLON: begin
          d_state = jpp_pkg::S_COLON;
        end
        jpp_pkg::CH_COMMA: begin
          d_comma = 1'b1;
          d_state = after_value;
        end
        jpp_pkg::CH_QUOTE: begin
          d_state  = pfx_state;
          d_comma  = 1'b0;
          d_opened = comma_pending ? opened_flag : 1'b0;
          d_instr  = 1'b1;
          d_bslash = 1'b0;
        end
        default: begin
          d_state  = pfx_state;
          d_comma  = 1'b0;
          d_opened = comma_pending ? opened_flag : 1'b0;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      jpp_pkg::S_IDLE: begin
        if (in_valid) state_next = jpp_pkg::S_DISPATCH;
      end
      jpp_pkg::S_DISPATCH: begin
        state_next = d_state;
      end
      jpp_pkg::S_COMMA: begin
        if (adv) state_next = room_ok ? jpp_pkg::S_NEWLINE : jpp_pkg::S_ERROR;
      end
      jpp_pkg::S_NEWLINE: begin
        if (adv) begin
          if (!room_ok) begin
            state_next = jpp_pkg::S_ERROR;
          end else begin
            state_next = (nl_depth == '0) ? jpp_pkg::S_CHAR : jpp_pkg::S_TABS;
          end
        end
      end
      jpp_pkg::S_TABS: begin
        if (adv && tab_cnt == jpp_pkg::DEPTH_W'(1)) state_next = jpp_pkg::S_CHAR;
      end
      jpp_pkg::S_CHAR: begin
        if (adv) state_next = room_ok ? after_value : jpp_pkg::S_ERROR;
      end
      jpp_pkg::S_COLON: begin
        if (adv) state_next = room_ok ? jpp_pkg::S_SPACE : jpp_pkg::S_ERROR;
      end
      jpp_pkg::S_SPACE: begin
        if (adv) state_next = after_value;
      end
      jpp_pkg::S_END, jpp_pkg::S_ERROR: begin
        if (adv) state_next = jpp_pkg::S_IDLE;
      end
      default: state_next = jpp_pkg::S_IDLE;
    endcase
  end

  // outputs and document state
  logic               emit;
  jpp_pkg::res_item_t emit_item;
  logic               clear_doc;

  always_comb begin
    nesting_depth_next   = nesting_depth;
    opened_flag_next     = opened_flag;
    comma_pending_next   = comma_pending;
    inside_string_next   = inside_string;
    after_backslash_next = after_backslash;
    bytes_written_next   = bytes_written;
    failed_flag_next     = failed_flag;
    nl_depth_next        = nl_depth;
    tab_cnt_next         = tab_cnt;
    emit                 = 1'b0;
    emit_item            = '{out_byte: 8'h00, out_valid: 1'b1, doc_done: 1'b0,
                             doc_error: 1'b0};
    clear_doc            = 1'b0;
    case (state)
      jpp_pkg::S_DISPATCH: begin
        nesting_depth_next   = d_depth;
        opened_flag_next     = d_opened;
        comma_pending_next   = d_comma;
        inside_string_next   = d_instr;
        after_backslash_next = d_bslash;
        nl_depth_next        = d_nl_depth;
      end
      jpp_pkg::S_COMMA: begin
        emit               = adv && room_ok;
        emit_item.out_byte = jpp_pkg::CH_COMMA;
      end
      jpp_pkg::S_NEWLINE: begin
        emit               = adv && room_ok;
        emit_item.out_byte = jpp_pkg::CH_NL;
        tab_cnt_next       = nl_depth;
      end
      jpp_pkg::S_TABS: begin
        emit               = adv;
        emit_item.out_byte = jpp_pkg::CH_TAB;
        if (adv) tab_cnt_next = tab_cnt - jpp_pkg::DEPTH_W'(1);
      end
      jpp_pkg::S_CHAR: begin
        emit               = adv && room_ok;
        emit_item.out_byte = cur.in_byte;
      end
      jpp_pkg::S_COLON: begin
        emit               = adv && room_ok;
        emit_item.out_byte = jpp_pkg::CH_COLON;
      end
      jpp_pkg::S_SPACE: begin
        emit               = adv;
        emit_item.out_byte = jpp_pkg::CH_SP;
      end
      jpp_pkg::S_END: begin
        // clean end needs a closed string, depth zero and room for '\n'
        emit = adv;
        if (!inside_string && nesting_depth == '0 && room_ok) begin
          emit_item = '{out_byte: jpp_pkg::CH_NL, out_valid: 1'b1, doc_done: 1'b1,
                        doc_error: 1'b0};
        end else begin
          emit_item = '{out_byte: 8'h00, out_valid: 1'b0, doc_done: 1'b1,
                        doc_error: 1'b1};
        end
        clear_doc = adv;
      end
      jpp_pkg::S_ERROR: begin
        emit      = adv;
        emit_item = '{out_byte: 8'h00, out_valid: 1'b0, doc_done: cur.end_of_doc,
                      doc_error: 1'b1};
        if (adv) begin
          if (cur.end_of_doc) begin
            clear_doc = 1'b1;
          end else begin
            failed_flag_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (emit && emit_item.out_valid) begin
      bytes_written_next = bytes_written + jpp_pkg::CAP_W'(1);
    end
    if (clear_doc) begin
      nesting_depth_next   = '0;
      opened_flag_next     = 1'b0;
      comma_pending_next   = 1'b0;
      inside_string_next   = 1'b0;
      after_backslash_next = 1'b0;
      bytes_written_next   = '0;
      failed_flag_next     = 1'b0;
    end
    res_valid_next = emit || (res_valid && !res_ready);
    res_item_next  = emit ? emit_item : res_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= jpp_pkg::S_IDLE;
      output_capacity <= jpp_pkg::CAP_RESET;
      nesting_depth   <= '0;
      opened_flag     <= 1'b0;
      comma_pending   <= 1'b0;
      inside_string   <= 1'b0;
      after_backslash <= 1'b0;
      bytes_written   <= '0;
      failed_flag     <= 1'b0;
      nl_depth        <= '0;
      tab_cnt         <= '0;
      res_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      nesting_depth   <= nesting_depth_next;
      opened_flag     <= opened_flag_next;
      comma_pending   <= comma_pending_next;
      inside_string   <= inside_string_next;
      after_backslash <= after_backslash_next;
      bytes_written   <= bytes_written_next;
      failed_flag     <= failed_flag_next;
      nl_depth        <= nl_depth_next;
      tab_cnt         <= tab_cnt_next;
      res_valid       <= res_valid_next;
      if (cfg_we) output_capacity <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) cur <= in_item;
    res_item <= res_item_next;
  end

endmodule

@@ design/jpp_checker.sv @@
// Port-level checker for the JSON pretty printer, with its bind.
`include "json_pretty_printer_defines.svh"

module jpp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               res_valid,
  input logic               res_ready,
  input jpp_pkg::res_item_t res_item
);

  // an accepted item keeps the block busy for at least the decode cycle
  `JPP_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "ready right after accept")

  // a stalled result holds
  `JPP_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_item), "stalled result changed")

  // error items carry no byte
  `JPP_ASSERT_NOW(a_err_no_byte, clk, rst, res_valid && res_item.doc_error, !res_item.out_valid && res_item.out_byte == 8'h00, "error item carries a byte")

  // every item without a byte is an error item
  `JPP_ASSERT_NOW(a_nobyte_is_err, clk, rst, res_valid && !res_item.out_valid, res_item.doc_error, "empty item without error")

endmodule

bind json_pretty_printer jpp_checker u_jpp_checker (.*);

@@ dv/tb_top.sv @@
// Self-checking testbench for json_pretty_printer: directed, capacity, nesting and random documents.
`timescale 1ns / 100ps

module tb_top;

  // Data bytes used by the directed documents
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_TWO  = 8'h32;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_HIGH = 8'hFF;

  // Cycles to let the block settle after the last expected result. A byte
  // that emits nothing (whitespace, comma, dropped input) still occupies the
  // sequencer in its S_DISPATCH state.
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 100;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  jpp_pkg::in_item_t in_item;
  logic res_valid;
  logic res_ready;
  jpp_pkg::res_item_t res_item;
  logic cfg_we;
  logic [jpp_pkg::CAP_W-1:0] cfg_wdata;

  always #2 clk = ~clk;

  json_pretty_printer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Formatter prediction: own copy of the register and the per-document state.
  // ---------------------------------------------------------------------------
  logic [jpp_pkg::CAP_W-1:0]   fmt_cap;
  logic [jpp_pkg::DEPTH_W-1:0] fmt_depth;
  logic [jpp_pkg::CAP_W-1:0]   fmt_written;
  bit                 fmt_opened;     // just opened a bracket, no entry yet
  bit                 fmt_comma;      // comma held back until the next value
  bit                 fmt_in_str;
  bit                 fmt_escape;     // previous string byte was a backslash
  bit                 fmt_failed;     // dropping input until end of document
  int                 fmt_deepest;
  jpp_pkg::res_item_t fmt_expect_q[$];

  int n_items;
  int n_results;
  int n_docs;
  int n_bad_docs;
  int n_fail;

  function automatic void clear_doc_state();
    fmt_depth   = '0;
    fmt_written = '0;
    fmt_opened  = 1'b0;
    fmt_comma   = 1'b0;
    fmt_in_str  = 1'b0;
    fmt_escape  = 1'b0;
    fmt_failed  = 1'b0;
  endfunction

  function automatic void push_result(logic [7:0] b, bit v, bit d, bit e);
    jpp_pkg::res_item_t r;
    r = '{out_byte: b, out_valid: v, doc_done: d, doc_error: e};
    fmt_expect_q.push_back(r);
    if (d) n_docs++;
    if (d && e) n_bad_docs++;
  endfunction

  // Capacity check done in 32 bits, so the sum never wraps.
  function automatic bit room_for(int unsigned k);
    return ({12'd0, fmt_written} + k) <= {12'd0, fmt_cap};
  endfunction

  function automatic bit emit_byte(logic [7:0] b);
    if (!room_for(1)) return 1'b0;
    push_result(b, 1'b1, 1'b0, 1'b0);
    fmt_written = fmt_written + 1'b1;
    return 1'b1;
  endfunction

  // Newline plus tabs is checked as one block before any byte goes out.
  function automatic bit emit_newline();
    int i;
    if (!room_for(32'(fmt_depth) + 1)) return 1'b0;
    void'(emit_byte(jpp_pkg::CH_NL));
    for (i = 0; i < int'(fmt_depth); i++) void'(emit_byte(jpp_pkg::CH_TAB));
    return 1'b1;
  endfunction

  // Held comma, or first entry after an opening bracket, goes out before a value.
  function automatic bit emit_prefix();
    if (fmt_comma) begin
      if (!emit_byte(jpp_pkg::CH_COMMA) || !emit_newline()) return 1'b0;
      fmt_comma = 1'b0;
    end else if (fmt_opened) begin
      if (!emit_newline()) return 1'b0;
      fmt_opened = 1'b0;
    end
    return 1'b1;
  endfunction

  // One JSON byte; returns 0 on any error.
  function automatic bit format_byte(logic [7:0] c);
    if (fmt_in_str) begin
      if (fmt_escape) begin
        fmt_escape = 1'b0;
        return emit_byte(c);
      end
      if (c == jpp_pkg::CH_NUL || c == jpp_pkg::CH_CR || c == jpp_pkg::CH_NL) return 1'b0;
      if (c == jpp_pkg::CH_QUOTE) fmt_in_str = 1'b0;
      else if (c == jpp_pkg::CH_BSLASH) fmt_escape = 1'b1;
      return emit_byte(c);
    end
    case (c)
      jpp_pkg::CH_SP, jpp_pkg::CH_TAB, jpp_pkg::CH_NL, jpp_pkg::CH_CR: begin
        return 1'b1;
      end
      jpp_pkg::CH_LBRACE, jpp_pkg::CH_LBRACK: begin
        if (fmt_depth >= jpp_pkg::MAX_DEPTH) return 1'b0;
        if (!emit_prefix() || !emit_byte(c)) return 1'b0;
        fmt_opened = 1'b1;
        fmt_comma  = 1'b0;
        fmt_depth  = fmt_depth + 1'b1;
        if (int'(fmt_depth) > fmt_deepest) fmt_deepest = int'(fmt_depth);
        return 1'b1;
      end
      jpp_pkg::CH_RBRACE, jpp_pkg::CH_RBRACK: begin
        if (fmt_depth == 0) return 1'b0;
        fmt_depth = fmt_depth - 1'b1;
        // a non-empty container closes on its own line; a trailing comma is lost
        if (!fmt_opened && !emit_newline()) return 1'b0;
        fmt_opened = 1'b0;
        fmt_comma  = 1'b0;
        return emit_byte(c);
      end
      jpp_pkg::CH_COLON: begin
        if (!room_for(2)) return 1'b0;
        void'(emit_byte(jpp_pkg::CH_COLON));
        void'(emit_byte(jpp_pkg::CH_SP));
        return 1'b1;
      end
      jpp_pkg::CH_COMMA: begin
        fmt_comma = 1'b1;
        return 1'b1;
      end
      jpp_pkg::CH_QUOTE: begin
        if (!emit_prefix() || !emit_byte(c)) return 1'b0;
        fmt_in_str = 1'b1;
        fmt_escape = 1'b0;
        return 1'b1;
      end
      default: begin
        if (!emit_prefix()) return 1'b0;
        return emit_byte(c);
      end
    endcase
  endfunction

  // Expected results of one accepted input item.
  function automatic void format_step(jpp_pkg::in_item_t it);
    if (fmt_failed) begin
      if (it.end_of_doc) begin
        push_result(8'h00, 1'b0, 1'b1, 1'b1);
        clear_doc_state();
      end
      return;
    end
    if (it.byte_valid && !format_byte(it.in_byte)) begin
      push_result(8'h00, 1'b0, it.end_of_doc, 1'b1);
      if (it.end_of_doc) clear_doc_state();
      else fmt_failed = 1'b1;
      return;
    end
    if (it.end_of_doc) begin
      if (fmt_in_str || fmt_depth != 0 || !room_for(1))
        push_result(8'h00, 1'b0, 1'b1, 1'b1);
      else
        push_result(jpp_pkg::CH_NL, 1'b1, 1'b1, 1'b0);
      clear_doc_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string nm, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, nm, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin
    jpp_pkg::res_item_t want;
    if (!rst && res_valid && res_ready) begin
      n_results++;
      if (fmt_expect_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none actual byte %02h valid %0b done %0b err %0b",
                 $time, res_item.out_byte, res_item.out_valid, res_item.doc_done,
                 res_item.doc_error);
        n_fail++;
      end else begin
        want = fmt_expect_q.pop_front();
        check_field("out_byte", 32'(want.out_byte), 32'(res_item.out_byte));
        check_field("out_valid", 32'(want.out_valid), 32'(res_item.out_valid));
        check_field("doc_done", 32'(want.doc_done), 32'(res_item.doc_done));
        check_field("doc_error", 32'(want.doc_error), 32'(res_item.doc_error));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a randomly chosen pattern that is redrawn whenever its stretch ends.
  // A test can ask for a long hold-off through hold_cycles_req; the count is
  // kept here so the sender is free to keep pushing items meanwhile.
  // ---------------------------------------------------------------------------
  int hold_cycles_req;

  initial begin
    int mode;
    int left;
    int n;
    res_ready = 1'b0;
    hold_cycles_req = 0;
    left = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles_req != 0) begin
        n = hold_cycles_req;
        hold_cycles_req = 0;
        res_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(32, 128);
      end
      left--;
      case (mode)
        0: res_ready <= 1'b1;                          // no stalls at all
        1: res_ready <= 1'($urandom_range(0, 1));
        2: res_ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
        default: res_ready <= (left % 4 != 0);         // regular on/off pattern, mostly on
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps in between.
  // ---------------------------------------------------------------------------
  int burst_left;

  task automatic send_item(input jpp_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    format_step(it);
    n_items++;
  endtask

  function automatic jpp_pkg::in_item_t byte_item(logic [7:0] b, bit eod);
    return '{in_byte: b, byte_valid: 1'b1, end_of_doc: eod};
  endfunction

  // No byte: an idle item, or a bare end marker when eod is set.
  function automatic jpp_pkg::in_item_t marker_item(bit eod);
    return '{in_byte: 8'($urandom_range(0, 255)), byte_valid: 1'b0, end_of_doc: eod};
  endfunction

  // Stop offering, wait out every expected result, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (fmt_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Capacity is only changed with the block idle and between documents.
  task automatic write_capacity(input logic [jpp_pkg::CAP_W-1:0] v);
    wait_drained();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we  <= 1'b0;
    fmt_cap = v;
  endtask

  // ---------------------------------------------------------------------------
  // Document generator: mostly well-formed JSON with random content and
  // whitespace, some of it broken afterwards.
  // ---------------------------------------------------------------------------
  logic [7:0] doc_q[$];
  bit         lvl_is_obj[$];
  int         lvl_count[$];

  task automatic add_ws();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0: doc_q.push_back(jpp_pkg::CH_SP);
      1: doc_q.push_back(jpp_pkg::CH_TAB);
      2: doc_q.push_back(jpp_pkg::CH_NL);
      3: doc_q.push_back(jpp_pkg::CH_CR);
      default: ;
    endcase
  endtask

  task automatic add_string();
    int n;
    logic [7:0] b;
    doc_q.push_back(jpp_pkg::CH_QUOTE);
    n = $urandom_range(0, 4);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        // escape: the byte after the backslash may be anything, NUL/CR/LF too
        doc_q.push_back(jpp_pkg::CH_BSLASH);
        doc_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        do b = 8'($urandom_range(1, 255));
        while (b inside {jpp_pkg::CH_NL, jpp_pkg::CH_CR, jpp_pkg::CH_QUOTE,
                         jpp_pkg::CH_BSLASH});
        doc_q.push_back(b);
      end
    end
    doc_q.push_back(jpp_pkg::CH_QUOTE);
  endtask

  task automatic add_scalar();
    int n;
    logic [7:0] b;
    n = $urandom_range(1, 4);
    repeat (n) begin
      do b = 8'($urandom_range(0, 255));
      while (b inside {jpp_pkg::CH_SP, jpp_pkg::CH_TAB, jpp_pkg::CH_NL, jpp_pkg::CH_CR,
                       jpp_pkg::CH_LBRACE, jpp_pkg::CH_RBRACE, jpp_pkg::CH_LBRACK,
                       jpp_pkg::CH_RBRACK, jpp_pkg::CH_COLON, jpp_pkg::CH_COMMA,
                       jpp_pkg::CH_QUOTE});
      doc_q.push_back(b);
    end
  endtask

  task automatic open_level();
    bit obj;
    obj = 1'($urandom_range(0, 1));
    doc_q.push_back(obj ? jpp_pkg::CH_LBRACE : jpp_pkg::CH_LBRACK);
    lvl_is_obj.push_back(obj);
    lvl_count.push_back(0);
    add_ws();
  endtask

  task automatic build_doc(input int max_depth);
    int steps;
    int r;
    int top;
    doc_q.delete();
    lvl_is_obj.delete();
    lvl_count.delete();
    if ($urandom_range(0, 5) == 0) begin
      // bare top-level value
      if ($urandom_range(0, 1) == 1) add_string();
      else add_scalar();
      return;
    end
    open_level();
    steps = 0;
    while (lvl_is_obj.size() != 0) begin
      steps++;
      top = lvl_is_obj.size() - 1;
      if (steps > 12 || $urandom_range(0, 3) == 0) begin
        // close the innermost level, now and then after a trailing comma
        if (lvl_count[top] > 0 && $urandom_range(0, 7) == 0) doc_q.push_back(jpp_pkg::CH_COMMA);
        add_ws();
        doc_q.push_back(lvl_is_obj[top] ? jpp_pkg::CH_RBRACE : jpp_pkg::CH_RBRACK);
        void'(lvl_is_obj.pop_back());
        void'(lvl_count.pop_back());
        add_ws();
      end else begin
        if (lvl_count[top] > 0) begin
          doc_q.push_back(jpp_pkg::CH_COMMA);
          add_ws();
        end
        lvl_count[top]++;
        if (lvl_is_obj[top]) begin
          add_string();
          add_ws();
          doc_q.push_back(jpp_pkg::CH_COLON);
          add_ws();
        end
        r = $urandom_range(0, 3);
        if (r == 0 && lvl_is_obj.size() < max_depth) open_level();
        else if (r == 1) add_string();
        else add_scalar();
      end
    end
  endtask

  // Ends on the last byte or on a bare end marker; idle items mixed in.
  task automatic send_doc();
    bit on_byte;
    int i;
    on_byte = 1'($urandom_range(0, 1));
    for (i = 0; i < doc_q.size(); i++) begin
      if ($urandom_range(0, 15) == 0) send_item(marker_item(1'b0));
      send_item(byte_item(doc_q[i], on_byte && i == doc_q.size() - 1));
    end
    if (!on_byte) send_item(marker_item(1'b1));
  endtask

  task automatic run_docs(input int n_doc, input int max_depth);
    int pos;
    int r;
    repeat (n_doc) begin
      build_doc(max_depth);
      pos = $urandom_range(0, doc_q.size() - 1);
      r = $urandom_range(0, 5);
      case (r)
        0: doc_q[pos] = 8'($urandom_range(0, 255));        // random byte anywhere
        1: while (doc_q.size() > pos + 1) void'(doc_q.pop_back()); // cut short
        2: doc_q.insert(pos, ($urandom_range(0, 1) == 1) ? jpp_pkg::CH_RBRACE
                                                         : jpp_pkg::CH_RBRACK);
        default: ;
      endcase
      send_doc();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every construct once: empty document, escapes, empty array, trailing
  // comma, non-ASCII value, whitespace of each kind, idle item.
  task automatic test_formatting();
    send_item(marker_item(1'b1));
    send_item(byte_item(jpp_pkg::CH_LBRACE, 1'b0));
    send_item(byte_item(jpp_pkg::CH_QUOTE, 1'b0));
    send_item(byte_item(jpp_pkg::CH_BSLASH, 1'b0));
    send_item(byte_item(jpp_pkg::CH_NUL, 1'b0));      // escaped NUL is copied
    send_item(byte_item(jpp_pkg::CH_QUOTE, 1'b0));
    send_item(byte_item(jpp_pkg::CH_SP, 1'b0));
    send_item(byte_item(jpp_pkg::CH_COLON, 1'b0));
    send_item(byte_item(jpp_pkg::CH_TAB, 1'b0));
    send_item(byte_item(jpp_pkg::CH_LBRACK, 1'b0));
    send_item(byte_item(jpp_pkg::CH_RBRACK, 1'b0));   // stays collapsed
    send_item(byte_item(jpp_pkg::CH_COMMA, 1'b0));
    send_item(byte_item(jpp_pkg::CH_NL, 1'b0));
    send_item(byte_item(CH_HIGH, 1'b0));
    send_item(marker_item(1'b0));
    send_item(byte_item(jpp_pkg::CH_COMMA, 1'b0));    // trailing, dropped at close
    send_item(byte_item(jpp_pkg::CH_CR, 1'b0));
    send_item(byte_item(jpp_pkg::CH_RBRACE, 1'b1));
  endtask

  task automatic test_error_cases();
    send_item(byte_item(jpp_pkg::CH_RBRACE, 1'b1));   // close at depth zero
    send_item(byte_item(jpp_pkg::CH_QUOTE, 1'b0));
    send_item(byte_item(jpp_pkg::CH_CR, 1'b0));       // raw CR in a string
    send_item(byte_item(CH_X, 1'b0));                 // dropped after the error
    send_item(marker_item(1'b1));
    send_item(byte_item(jpp_pkg::CH_LBRACK, 1'b1));   // open container at the end
    send_item(byte_item(jpp_pkg::CH_QUOTE, 1'b1));    // unclosed string
  endtask

  // Full depth, a comma-separated pair at the bottom, then one level too deep.
  task automatic test_deep_nesting();
    int i;
    for (i = 0; i < jpp_pkg::MAX_DEPTH; i++) send_item(byte_item(jpp_pkg::CH_LBRACK, 1'b0));
    send_item(byte_item(CH_ONE, 1'b0));
    send_item(byte_item(jpp_pkg::CH_COMMA, 1'b0));
    send_item(byte_item(CH_TWO, 1'b0));
    for (i = 0; i < jpp_pkg::MAX_DEPTH; i++)
      send_item(byte_item(jpp_pkg::CH_RBRACK, i == jpp_pkg::MAX_DEPTH - 1));
    for (i = 0; i <= jpp_pkg::MAX_DEPTH; i++) send_item(byte_item(jpp_pkg::CH_LBRACE, 1'b0));
    send_item(marker_item(1'b1));
  endtask

  task automatic test_capacity_limits();
    write_capacity(20'd1);
    run_docs(1, 3);
    write_capacity(20'd2);
    run_docs(1, 3);
    repeat (2) begin
      write_capacity(jpp_pkg::CAP_W'($urandom_range(3, 40)));
      run_docs(1, 3);
    end
    write_capacity(jpp_pkg::CAP_RESET);
  endtask

  // Receiver stops for a long stretch while documents keep coming.
  task automatic test_output_stall();
    hold_cycles_req = 400;
    run_docs(1, 4);
    wait_drained();
  endtask

  task automatic test_random_docs();
    int start;
    start = n_items;
    while (n_items - start < RANDOM_ITEMS / 2) run_docs(1, $urandom_range(1, 6));
    write_capacity(jpp_pkg::CAP_W'($urandom_range(20, 200)));
    while (n_items - start < RANDOM_ITEMS) run_docs(1, $urandom_range(1, 6));
    write_capacity(jpp_pkg::CAP_RESET);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    burst_left  = 0;
    n_items     = 0;
    n_results   = 0;
    n_docs      = 0;
    n_bad_docs  = 0;
    n_fail      = 0;
    fmt_deepest = 0;
    fmt_cap     = jpp_pkg::CAP_RESET;
    clear_doc_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_formatting();
    test_error_cases();
    test_deep_nesting();
    test_capacity_limits();
    test_output_stall();
    test_random_docs();
    wait_drained();

    $display("Covered %0d input items, %0d results, %0d documents (%0d failed by design).",
             n_items, n_results, n_docs, n_bad_docs);
    $display("Deepest nesting %0d; capacities from 1 up to %0d, long output stall included.",
             fmt_deepest, jpp_pkg::CAP_RESET);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
